// ===== design/bii_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bilinear image interpolator.
package bii_pkg;

    // Store geometry and number format
    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int FRAC_BITS = 8;

    // Field widths fixed by the interface
    localparam int ROW_W    = 8;
    localparam int COL_W    = 8;
    localparam int PIX_W    = 16;
    localparam int COORD_W  = 17;
    localparam int SIZE_W   = 9;
    localparam int CFG_IX_W = 1;

    localparam int WHOLE_W = COORD_W - FRAC_BITS;
    localparam int ONE_W   = FRAC_BITS + 1;
    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

    // Weight and accumulator widths
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int PROD_W = WGT_W + PIX_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (2 * FRAC_BITS - 1);

    // Four banks split by row parity and column parity
    localparam int NBANK      = 4;
    localparam int RA_W       = $clog2(MAX_ROWS / 2);
    localparam int CA_W       = $clog2(MAX_COLS / 2);
    localparam int BANK_AW    = RA_W + CA_W;
    localparam int BANK_DEPTH = (MAX_ROWS / 2) * (MAX_COLS / 2);

    localparam logic [SIZE_W-1:0] SIZE_MAX_ROWS = SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] SIZE_MAX_COLS = SIZE_W'(MAX_COLS);

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IX_W-1:0] REG_COLS = 1'b1;

    typedef struct packed {
        logic               op;
        logic [ROW_W-1:0]   pixel_row;
        logic [COL_W-1:0]   pixel_col;
        logic [PIX_W-1:0]   pixel_value;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_x;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] interpolated_value;
        logic             out_of_range;
    } t_out_item;

    // Clamp a size register write into 1..top
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] top);
        logic [SIZE_W-1:0] r;
        begin
            if (v == '0) begin
                r = SIZE_W'(1);
            end else if (v > top) begin
                r = top;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

// ===== design/bilinear_image_interpolator_core.sv =====
`timescale 1ns / 1ps
// Top level: banked image store with a pipelined bilinear interpolator.
//
// Usage:
//   Input channel (i_valid / o_stall / i_data) carries one transaction per
//   item. op = write places pixel_value at (pixel_row, pixel_col); op = query
//   asks for the interpolated pixel at one-based Q9.8 (coord_y, coord_x).
//   Writes produce no result; every query produces exactly one result on the
//   output channel (o_valid / i_stall / o_data). Configuration channel
//   (i_cfg_valid / o_cfg_ready) sets image_rows (index 0) and image_cols
//   (index 1); write it only while the block is idle.
// Flow:
//   One transaction per cycle sustained while i_stall stays low. A query's
//   bank read registers at its accepting edge, then the four
//   weight-times-pixel products, then the rounded sum in the output register,
//   which drives o_valid. Four banks split by row and column parity deliver the
//   whole 2x2 neighborhood in one read; a write is visible to the next query.
// Reset and stall:
//   Reset clears the pipeline valids and sets both sizes to 256; the store
//   must be written before it is read. A stage holds while the next is full
//   and held; o_stall rises once every stage is full and i_stall is high.
module bilinear_image_interpolator_core
    import bii_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_in_item            i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output t_out_item           o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]   i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SIZE_W-1:0] r_rows, r_cols;
    logic [SIZE_W-1:0] n_rows, n_cols;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROWS: n_rows = clamp_size(i_cfg_data, SIZE_MAX_ROWS);
                REG_COLS: n_cols = clamp_size(i_cfg_data, SIZE_MAX_COLS);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= SIZE_MAX_ROWS;
            r_cols <= SIZE_MAX_COLS;
        end else begin
            r_rows <= n_rows;
            r_cols <= n_cols;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline handshake: each stage advances when the next is free
    // ---------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic rdy1, rdy2, rdy3;
    logic acc;

    assign rdy3    = !r_out_valid || !i_stall;
    assign rdy2    = !r_s2_valid || rdy3;
    assign rdy1    = !r_s1_valid || rdy2;
    assign o_stall = !rdy1;
    assign acc     = i_valid && rdy1;

    // ---------------------------------------------------------------
    // Stage 0: split coordinates, range check, weights, bank addresses
    // ---------------------------------------------------------------
    logic [WHOLE_W-1:0]   y, x, r0, c0;
    logic [FRAC_BITS-1:0] fy, fx;
    logic [ONE_W-1:0]     omfy, omfx, fy_e, fx_e;
    logic                 in_y, in_x;
    logic [WGT_W-1:0]     wfull [NBANK];
    logic [WHOLE_W-1:0]   row_by_par [2];
    logic [WHOLE_W-1:0]   col_by_par [2];
    logic [BANK_AW-1:0]   rd_addr [NBANK];
    logic [BANK_AW-1:0]   wr_addr;
    logic [1:0]           wr_bank;
    logic                 wr_en, rd_en;

    assign y    = i_data.coord_y[COORD_W-1:FRAC_BITS];
    assign x    = i_data.coord_x[COORD_W-1:FRAC_BITS];
    assign fy   = i_data.coord_y[FRAC_BITS-1:0];
    assign fx   = i_data.coord_x[FRAC_BITS-1:0];
    assign fy_e = {1'b0, fy};
    assign fx_e = {1'b0, fx};
    assign omfy = ONE - fy_e;
    assign omfx = ONE - fx_e;
    assign r0   = y - WHOLE_W'(1);
    assign c0   = x - WHOLE_W'(1);

    // inside when 1 <= coord <= size, as a real number
    assign in_y = (y != '0) && (y <= r_rows) && !((y == r_rows) && (fy != '0));
    assign in_x = (x != '0) && (x <= r_cols) && !((x == r_cols) && (fx != '0));

    // neighbor order: A (r0,c0), B (r1,c0), C (r0,c1), D (r1,c1)
    assign wfull[0] = omfy * omfx;
    assign wfull[1] = fy_e * omfx;
    assign wfull[2] = omfy * fx_e;
    assign wfull[3] = fy_e * fx_e;

    // the two neighbor rows (and columns) always have opposite parity
    always_comb begin
        row_by_par[0] = r0[0] ? y : r0;
        row_by_par[1] = r0[0] ? r0 : y;
        col_by_par[0] = c0[0] ? x : c0;
        col_by_par[1] = c0[0] ? c0 : x;
        for (int b = 0; b < NBANK; b++) begin
            rd_addr[b] = {row_by_par[b / 2][RA_W:1], col_by_par[b % 2][CA_W:1]};
        end
    end

    assign wr_en   = acc && (i_data.op == OP_WRITE);
    assign rd_en   = acc && (i_data.op == OP_QUERY);
    assign wr_bank = {i_data.pixel_row[0], i_data.pixel_col[0]};
    assign wr_addr = {i_data.pixel_row[RA_W:1], i_data.pixel_col[CA_W:1]};

    // ---------------------------------------------------------------
    // Image store: four banks, registered read
    // ---------------------------------------------------------------
    logic [PIX_W-1:0] r_rd [NBANK];

    for (genvar b = 0; b < NBANK; b++) begin : g_bank
        logic [PIX_W-1:0] r_mem [BANK_DEPTH];

        always_ff @(posedge i_clk) begin
            if (wr_en && (wr_bank == 2'(b))) begin
                r_mem[wr_addr] <= i_data.pixel_value;
            end
            if (rd_en) begin
                r_rd[b] <= r_mem[rd_addr[b]];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 registers: weights, edge masks, parity of the first neighbor
    // ---------------------------------------------------------------
    logic             r_s1_oor;
    logic [WGT_W-1:0] r_s1_w [NBANK];
    logic [NBANK-1:0] r_s1_zero;
    logic             r_s1_r0p, r_s1_c0p;
    logic             zr1, zc1;

    // the neighbor past the last row or column has zero weight: read it as zero
    assign zr1 = (y == r_rows);
    assign zc1 = (x == r_cols);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rdy1) begin
            r_s1_valid <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_oor  <= !(in_y && in_x);
            r_s1_zero <= {zr1 || zc1, zc1, zr1, 1'b0};
            r_s1_r0p  <= r0[0];
            r_s1_c0p  <= c0[0];
            for (int k = 0; k < NBANK; k++) begin
                r_s1_w[k] <= wfull[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: route bank data to neighbors, weight each pixel
    // ---------------------------------------------------------------
    logic [PIX_W-1:0]  pix [NBANK];
    logic [1:0]        nb_bank [NBANK];
    logic              r_s2_oor;
    logic [PROD_W-1:0] r_s2_p [NBANK];

    always_comb begin
        nb_bank[0] = { r_s1_r0p,  r_s1_c0p};
        nb_bank[1] = {~r_s1_r0p,  r_s1_c0p};
        nb_bank[2] = { r_s1_r0p, ~r_s1_c0p};
        nb_bank[3] = {~r_s1_r0p, ~r_s1_c0p};
        for (int k = 0; k < NBANK; k++) begin
            pix[k] = r_s1_zero[k] ? '0 : r_rd[nb_bank[k]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_s1_valid) begin
            r_s2_oor <= r_s1_oor;
            for (int k = 0; k < NBANK; k++) begin
                r_s2_p[k] <= r_s1_w[k] * pix[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: sum, round half up, output register
    // ---------------------------------------------------------------
    logic [SUM_W-1:0] sum;
    t_out_item        r_out;
    t_out_item        n_out;

    assign sum = SUM_W'(r_s2_p[0]) + SUM_W'(r_s2_p[1]) + SUM_W'(r_s2_p[2])
               + SUM_W'(r_s2_p[3]) + RND;

    always_comb begin
        n_out.out_of_range       = r_s2_oor;
        n_out.interpolated_value = r_s2_oor ? '0
                                            : sum[2*FRAC_BITS +: PIX_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_s2_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_data.op == OP_WRITE)) |=> !r_s1_valid)
        else $error("write transaction entered the result pipe");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.out_of_range) |-> (o_data.interpolated_value == '0))
        else $error("out-of-range result carries a nonzero value");

    a_sizes_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rows != '0) && (r_rows <= SIZE_MAX_ROWS)
        && (r_cols != '0) && (r_cols <= SIZE_MAX_COLS))
        else $error("size register outside its clamped range");

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && rdy3) |=> o_valid)
        else $error("result lost between product stage and output");

endmodule

// ===== tb/tb_bilinear_image_interpolator_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bilinear image interpolator core.
module tb_bilinear_image_interpolator_core;
    import bii_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS  = 130;
    localparam int NUM_PHASES   = 7;
    localparam int FRAC_MAX     = (1 << FRAC_BITS) - 1;

    // Mirror of the image store and size registers; predicts one pixel per query
    // and holds the predictions until the block delivers them.
    class interp_checker;
        bit [PIX_W-1:0] image_copy [MAX_ROWS][MAX_COLS];
        bit             written    [MAX_ROWS][MAX_COLS];
        int unsigned    rows_cfg;
        int unsigned    cols_cfg;
        t_out_item      pending_pixels [$];
        int             failures;

        function new();
            rows_cfg = MAX_ROWS;
            cols_cfg = MAX_COLS;
            failures = 0;
        endfunction

        function void set_size(logic [CFG_IX_W-1:0] index, logic [SIZE_W-1:0] value);
            int unsigned v;
            v = value;
            if (index == REG_ROWS) begin
                rows_cfg = (v < 1) ? 1 : ((v > MAX_ROWS) ? MAX_ROWS : v);
            end else begin
                cols_cfg = (v < 1) ? 1 : ((v > MAX_COLS) ? MAX_COLS : v);
            end
        endfunction

        function bit in_image(logic [COORD_W-1:0] coord, int unsigned lim);
            int unsigned whole;
            int unsigned frac;
            whole = coord >> FRAC_BITS;
            frac  = coord & FRAC_MAX;
            return (whole >= 1) && ((whole < lim) || (whole == lim && frac == 0));
        endfunction

        function longint unsigned pixel_at(int unsigned r, int unsigned c);
            if (r >= rows_cfg || c >= cols_cfg) begin
                return 0;
            end
            return image_copy[r][c];
        endfunction

        function t_out_item interpolate(logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cx);
            t_out_item         res;
            longint unsigned   one;
            longint unsigned   fy;
            longint unsigned   fx;
            int unsigned       y;
            int unsigned       x;
            longint unsigned   acc;
            res = '0;
            if (!in_image(cy, rows_cfg) || !in_image(cx, cols_cfg)) begin
                res.out_of_range = 1'b1;
                return res;
            end
            one = longint'(1) << FRAC_BITS;
            fy  = cy & FRAC_MAX;
            fx  = cx & FRAC_MAX;
            y   = cy >> FRAC_BITS;
            x   = cx >> FRAC_BITS;
            acc = (one - fy) * (one - fx) * pixel_at(y - 1, x - 1)
                + fy * (one - fx) * pixel_at(y, x - 1)
                + (one - fy) * fx * pixel_at(y - 1, x)
                + fy * fx * pixel_at(y, x);
            acc = (acc + (longint'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
            res.interpolated_value = acc[PIX_W-1:0];
            return res;
        endfunction

        function void accept_item(t_in_item item);
            if (item.op == OP_WRITE) begin
                image_copy[item.pixel_row][item.pixel_col] = item.pixel_value;
                written[item.pixel_row][item.pixel_col]    = 1'b1;
            end else begin
                pending_pixels.push_back(interpolate(item.coord_y, item.coord_x));
            end
        endfunction

        function void check_pixel(t_out_item got);
            t_out_item want;
            if (pending_pixels.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: unexpected result value %h flag %b", $realtime,
                             got.interpolated_value, got.out_of_range);
                end
                return;
            end
            want = pending_pixels.pop_front();
            if (got.interpolated_value !== want.interpolated_value ||
                got.out_of_range !== want.out_of_range) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: mismatch: expected value %h flag %b, got value %h flag %b",
                             $realtime, want.interpolated_value, want.out_of_range,
                             got.interpolated_value, got.out_of_range);
                end
            end
        endfunction

        function void close_out();
            if (pending_pixels.size() != 0) begin
                $display("%0d results never arrived", pending_pixels.size());
                failures += pending_pixels.size();
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    t_in_item            i_data;
    logic                o_valid;
    logic                i_stall;
    t_out_item           o_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IX_W-1:0] i_cfg_index;
    logic [SIZE_W-1:0]   i_cfg_data;

    interp_checker sb;
    int            items_sent;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            cycle_count;

    bilinear_image_interpolator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog: abort a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: check each transaction taken at this edge, then pick the
    // stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            sb.check_pixel(o_data);
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic t_in_item make_write(int unsigned r, int unsigned c, int unsigned v);
        t_in_item item;
        item             = '0;
        item.op          = OP_WRITE;
        item.pixel_row   = ROW_W'(r);
        item.pixel_col   = COL_W'(c);
        item.pixel_value = PIX_W'(v);
        // Coordinates are don't-care on a write; randomize them anyway.
        item.coord_y     = COORD_W'($urandom);
        item.coord_x     = COORD_W'($urandom);
        return item;
    endfunction

    function automatic t_in_item make_query(logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cx);
        t_in_item item;
        item             = '0;
        item.op          = OP_QUERY;
        item.pixel_row   = ROW_W'($urandom);
        item.pixel_col   = COL_W'($urandom);
        item.pixel_value = PIX_W'($urandom);
        item.coord_y     = cy;
        item.coord_x     = cx;
        return item;
    endfunction

    // Coordinate inside 1..lim; whole numbers get extra weight.
    function automatic logic [COORD_W-1:0] pick_inside(int unsigned lim);
        int unsigned whole;
        int unsigned frac;
        whole = $urandom_range(lim, 1);
        frac  = (whole == lim || $urandom_range(6) == 0) ? 0 : $urandom_range(FRAC_MAX);
        return COORD_W'((whole << FRAC_BITS) | frac);
    endfunction

    // Coordinate just past the far edge or well beyond it.
    function automatic logic [COORD_W-1:0] pick_beyond(int unsigned lim);
        int unsigned whole;
        int unsigned frac;
        if ($urandom_range(1) == 0) begin
            whole = lim;
            frac  = $urandom_range(FRAC_MAX, 1);
        end else begin
            whole = $urandom_range((1 << (COORD_W - FRAC_BITS)) - 1, lim + 1);
            frac  = $urandom_range(FRAC_MAX);
        end
        return COORD_W'((whole << FRAC_BITS) | frac);
    endfunction

    // Drive one transaction, with random idle cycles ahead of it; hold the
    // payload until the block takes it.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_stall);
        sb.accept_item(item);
        items_sent++;
    endtask

    // Query a point; first write any neighbor inside the image that the store
    // has never held, so no query reads an undefined pixel.
    task automatic send_query(input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cx);
        int unsigned y;
        int unsigned x;
        int unsigned r;
        int unsigned c;
        if (sb.in_image(cy, sb.rows_cfg) && sb.in_image(cx, sb.cols_cfg)) begin
            y = cy >> FRAC_BITS;
            x = cx >> FRAC_BITS;
            for (r = y - 1; r <= y && r < sb.rows_cfg; r++) begin
                for (c = x - 1; c <= x && c < sb.cols_cfg; c++) begin
                    if (!sb.written[r][c]) begin
                        send_item(make_write(r, c, $urandom));
                    end
                end
            end
        end
        send_item(make_query(cy, cx));
    endtask

    // Drop valid, wait for every expected result, then let the pipe empty.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both size registers back to back while the block is idle.
    task automatic configure(input int unsigned rows_val, input int unsigned cols_val);
        logic [CFG_IX_W-1:0] ix [2];
        logic [SIZE_W-1:0]   val [2];
        int                  n;
        ix[0]  = REG_ROWS;
        ix[1]  = REG_COLS;
        val[0] = SIZE_W'(rows_val);
        val[1] = SIZE_W'(cols_val);
        settle();
        for (n = 0; n < 2; n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= ix[n];
            i_cfg_data  <= val[n];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_size(ix[n], val[n]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly in-image queries with their neighborhoods
    // written on demand, plus out-of-image queries and stray writes.
    task automatic run_random(input int budget);
        int                 start;
        int unsigned        pick;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cx;
        start = items_sent;
        while (items_sent - start < budget) begin
            pick = $urandom_range(99);
            cy   = pick_inside(sb.rows_cfg);
            cx   = pick_inside(sb.cols_cfg);
            if (pick < 60) begin
                send_query(cy, cx);
            end else if (pick < 80) begin
                case ($urandom_range(4))
                    0: begin
                        cy = COORD_W'($urandom);
                        cx = COORD_W'($urandom);
                    end
                    1: cy = pick_beyond(sb.rows_cfg);
                    2: cx = pick_beyond(sb.cols_cfg);
                    3: cy = COORD_W'($urandom_range(FRAC_MAX));
                    default: cx = COORD_W'($urandom_range(FRAC_MAX));
                endcase
                send_query(cy, cx);
            end else begin
                // Anywhere in the store, inside the image or not.
                send_item(make_write($urandom_range(MAX_ROWS - 1),
                                     $urandom_range(MAX_COLS - 1), $urandom));
            end
        end
    endtask

    initial begin
        int          k;
        int unsigned rows_val;
        int unsigned cols_val;

        sb             = new();
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_count    = 0;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        i_stall        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_ROWS;
        i_cfg_data     = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a 2x2 image holding the value extremes.
        configure(2, 2);
        send_item(make_write(0, 0, 16'h0000));
        send_item(make_write(1, 0, 16'h0001));
        send_item(make_write(0, 1, 16'hFFFF));
        send_item(make_write(1, 1, 16'hFFFF));
        send_query(17'h00100, 17'h00100);   // exact pixel
        send_query(17'h00180, 17'h00100);   // half between 0 and 1: rounds up
        send_query(17'h00200, 17'h00200);   // last row and last column
        send_query(17'h00200, 17'h00180);   // last row, fraction in x
        send_query(17'h00180, 17'h00200);   // last column, fraction in y
        send_query(17'h001FF, 17'h001FF);   // largest fractions
        send_query(17'h00180, 17'h00180);   // center of the cell
        send_query(17'h00000, 17'h00000);   // zero coordinate
        send_query(17'h000FF, 17'h00100);   // whole part zero in y
        send_query(17'h00100, 17'h00000);   // whole part zero in x
        send_query(17'h00201, 17'h00100);   // just past last row
        send_query(17'h00100, 17'h00201);   // just past last column
        send_query(17'h1FFFF, 17'h1FFFF);   // largest coordinates
        // Written outside the image but inside the store: must be kept.
        send_item(make_write(MAX_ROWS - 1, MAX_COLS - 1, 16'hA5A5));

        configure(MAX_ROWS, MAX_COLS);
        send_query(COORD_W'(MAX_ROWS << FRAC_BITS), COORD_W'(MAX_COLS << FRAC_BITS));
        send_query(COORD_W'(MAX_ROWS << FRAC_BITS), COORD_W'((MAX_COLS << FRAC_BITS) + 1));

        // Random phases; sizes sweep the extremes, clamped values included,
        // and the phases rotate through four idling patterns.
        for (k = 0; k < NUM_PHASES; k++) begin
            case (k)
                0: begin rows_val = 0;   cols_val = 511; end
                1: begin rows_val = 511; cols_val = 0;   end
                2: begin rows_val = 256; cols_val = 256; end
                3: begin rows_val = 3;   cols_val = 5;   end
                4: begin
                    rows_val = $urandom_range(16, 1);
                    cols_val = $urandom_range(16, 1);
                end
                5: begin
                    rows_val = $urandom_range(64, 2);
                    cols_val = $urandom_range(64, 2);
                end
                default: begin
                    rows_val = $urandom_range(300, 1);
                    cols_val = $urandom_range(300, 1);
                end
            endcase
            configure(rows_val, cols_val);
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            run_random(PHASE_ITEMS);
        end

        settle();
        sb.close_out();
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
